@@ design/edft_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edft_pkg - shared types and constants of the EDF task table
// Table depth, command and status codes, slot and cell control types.
// ----------------------------------------------------------------------------
package edft_pkg;

  localparam int unsigned MaxActive = 16;
  localparam int unsigned OccW      = $clog2(MaxActive + 1);
  localparam int unsigned CountW    = 5;
  localparam int unsigned DataW     = 32;

  localparam logic CmdRelease  = 1'b0;
  localparam logic CmdComplete = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNotFound = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  typedef struct packed {
    logic [DataW-1:0] deadline;
    logic [DataW-1:0] task_id;
  } slot_t;

  typedef struct packed {
    logic             update;
    logic             release_op;
    logic [DataW-1:0] deadline;
    logic [DataW-1:0] task_id;
  } cell_ctl_t;

endpackage : edft_pkg
`default_nettype wire

@@ design/edft_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edft_cell - one slot of the sorted task chain
// Holds one task and its deadline; on release it keeps, takes the new task
// or takes its left neighbor; on completion it keeps or takes its right one.
// ----------------------------------------------------------------------------
module edft_cell (
  input  wire logic              clk_i,
  input  wire edft_pkg::cell_ctl_t ctl_i,
  input  wire logic              valid_i,
  input  wire logic              keep_left_i,
  input  wire logic              seen_left_i,
  input  wire edft_pkg::slot_t   left_i,
  input  wire edft_pkg::slot_t   right_i,
  output logic                   keep_o,
  output logic                   seen_o,
  output edft_pkg::slot_t        slot_o
);
  import edft_pkg::*;

  slot_t slot_q, slot_d;
  logic  match;

  assign keep_o = valid_i && (slot_q.deadline <= ctl_i.deadline);
  assign match  = valid_i && (slot_q.task_id == ctl_i.task_id);
  assign seen_o = seen_left_i || match;

  always_comb begin
    slot_d = slot_q;
    if (ctl_i.update) begin
      if (ctl_i.release_op) begin
        if (!keep_o) begin
          if (keep_left_i) begin
            slot_d.deadline = ctl_i.deadline;
            slot_d.task_id  = ctl_i.task_id;
          end else begin
            slot_d = left_i;
          end
        end
      end else if (seen_o) begin
        slot_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule : edft_cell
`default_nettype wire

@@ design/edf_task_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_task_table - earliest-deadline-first task table
// Sorted chain of task cells with release/complete commands, head task
// output, active count and saturating on-time / late counters.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  command   start_i / busy_o          command_i, task_id_i, now_i,
//                                      relative_deadline_i, completion_time_i,
//                                      due_time_i
//  result    done_o (one-cycle strobe) run_valid_o, run_task_id_o,
//                                      active_count_o, completed_count_o,
//                                      overdue_count_o, status_o
//
//  An item is handled as capture and deadline add, then one chain update
//  in which every cell compares against the item and shifts in parallel.
//  done_o pulses in the cycle after the update; busy_o is high during the
//  update cycle, so a new item may start while done_o is shown.
//  Reset empties the table and clears both counters; no sweep is needed.
//  The receiver cannot stall: results appear once and are not held.
// ----------------------------------------------------------------------------
module edf_task_table (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        command_i,
  input  wire logic [edft_pkg::DataW-1:0]  task_id_i,
  input  wire logic [edft_pkg::DataW-1:0]  now_i,
  input  wire logic [edft_pkg::DataW-1:0]  relative_deadline_i,
  input  wire logic [edft_pkg::DataW-1:0]  completion_time_i,
  input  wire logic [edft_pkg::DataW-1:0]  due_time_i,
  output logic                             done_o,
  output logic                             run_valid_o,
  output logic [edft_pkg::DataW-1:0]       run_task_id_o,
  output logic [edft_pkg::CountW-1:0]      active_count_o,
  output logic [edft_pkg::DataW-1:0]       completed_count_o,
  output logic [edft_pkg::DataW-1:0]       overdue_count_o,
  output logic [1:0]                       status_o
);
  import edft_pkg::*;

  localparam logic [DataW-1:0] CntMax = '1;

  logic             exec_q;
  logic             done_q;
  logic             cmd_q;
  logic             late_q;
  logic [DataW-1:0] dl_q;
  logic [DataW-1:0] id_q;
  logic [OccW-1:0]  occ_q, occ_d;
  logic [DataW-1:0] on_time_q, on_time_d;
  logic [DataW-1:0] late_cnt_q, late_cnt_d;
  logic [1:0]       status_q, status_d;

  cell_ctl_t            ctl;
  logic                 full;
  logic                 found;
  logic [MaxActive:0]   keep_chain;
  logic [MaxActive:0]   seen_chain;
  slot_t                slots [MaxActive];

  assign full  = (occ_q == OccW'(MaxActive));
  assign found = seen_chain[MaxActive];

  assign ctl.update     = exec_q && !((cmd_q == CmdRelease) ? full : !found);
  assign ctl.release_op = (cmd_q == CmdRelease);
  assign ctl.deadline   = dl_q;
  assign ctl.task_id    = id_q;

  assign keep_chain[0] = 1'b1;
  assign seen_chain[0] = 1'b0;

  for (genvar g = 0; g < MaxActive; g++) begin : g_cell
    edft_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (occ_q > OccW'(g)),
      .keep_left_i (keep_chain[g]),
      .seen_left_i (seen_chain[g]),
      .left_i      ((g == 0) ? slots[0] : slots[(g == 0) ? 0 : g - 1]),
      .right_i     ((g == MaxActive - 1) ? slots[g] :
                    slots[(g == MaxActive - 1) ? g : g + 1]),
      .keep_o      (keep_chain[g+1]),
      .seen_o      (seen_chain[g+1]),
      .slot_o      (slots[g])
    );
  end

  always_comb begin
    occ_d      = occ_q;
    on_time_d  = on_time_q;
    late_cnt_d = late_cnt_q;
    status_d   = status_q;
    if (exec_q) begin
      status_d = StatusOk;
      if (cmd_q == CmdRelease) begin
        if (full) begin
          status_d = StatusFull;
        end else begin
          occ_d = occ_q + OccW'(1);
        end
      end else if (!found) begin
        status_d = StatusNotFound;
      end else begin
        occ_d = occ_q - OccW'(1);
        if (late_q) begin
          if (late_cnt_q != CntMax) late_cnt_d = late_cnt_q + DataW'(1);
        end else begin
          if (on_time_q != CntMax) on_time_d = on_time_q + DataW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q     <= 1'b0;
      done_q     <= 1'b0;
      occ_q      <= '0;
      on_time_q  <= '0;
      late_cnt_q <= '0;
      status_q   <= StatusOk;
    end else begin
      exec_q     <= start_i && !exec_q;
      done_q     <= exec_q;
      occ_q      <= occ_d;
      on_time_q  <= on_time_d;
      late_cnt_q <= late_cnt_d;
      status_q   <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !exec_q) begin
      cmd_q  <= command_i;
      id_q   <= task_id_i;
      dl_q   <= now_i + relative_deadline_i;
      late_q <= (completion_time_i > due_time_i);
    end
  end

  assign busy_o            = exec_q;
  assign done_o            = done_q;
  assign run_valid_o       = (occ_q != '0);
  assign run_task_id_o     = (occ_q != '0) ? slots[0].task_id : '0;
  assign active_count_o    = CountW'(occ_q);
  assign completed_count_o = on_time_q;
  assign overdue_count_o   = late_cnt_q;
  assign status_o          = status_q;

endmodule : edf_task_table
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the EDF task table
// Drives release and complete items from a backlog and predicts each result
// with a sorted shadow table, then compares every strobed result field by
// field. Directed items hit the wrap, tie, duplicate, full and miss cases.
// Random phases follow, with the release bias swept so the table fills and
// drains repeatedly.
// ----------------------------------------------------------------------------
module tb;
  import edft_pkg::*;

  localparam int StallLimit = 1000;

  typedef struct {
    logic             cmd;
    logic [DataW-1:0] id;
    logic [DataW-1:0] now;
    logic [DataW-1:0] rel;
    logic [DataW-1:0] fin;
    logic [DataW-1:0] due;
  } sched_cmd_t;

  typedef struct {
    logic              run_valid;
    logic [DataW-1:0]  run_id;
    logic [CountW-1:0] active;
    logic [DataW-1:0]  on_time;
    logic [DataW-1:0]  late;
    logic [1:0]        status;
  } sched_view_t;

  logic              clk_i               = 1'b0;
  logic              rst_ni              = 1'b0;
  logic              start_i             = 1'b0;
  logic              command_i           = CmdRelease;
  logic [DataW-1:0]  task_id_i           = '0;
  logic [DataW-1:0]  now_i               = '0;
  logic [DataW-1:0]  relative_deadline_i = '0;
  logic [DataW-1:0]  completion_time_i   = '0;
  logic [DataW-1:0]  due_time_i          = '0;
  logic              busy_o;
  logic              done_o;
  logic              run_valid_o;
  logic [DataW-1:0]  run_task_id_o;
  logic [CountW-1:0] active_count_o;
  logic [DataW-1:0]  completed_count_o;
  logic [DataW-1:0]  overdue_count_o;
  logic [1:0]        status_o;

  sched_cmd_t  cmd_backlog[$];
  sched_view_t view_expected[$];
  sched_cmd_t  on_bus;

  // shadow of the task table, earliest deadline first
  logic [DataW-1:0] shadow_dl[$];
  logic [DataW-1:0] shadow_task[$];
  logic [DataW-1:0] cnt_on_time = '0;
  logic [DataW-1:0] cnt_late    = '0;

  // ids the generator believes are live, to aim completes at real tasks
  logic [DataW-1:0] live_ids[$];

  int n_items = 0;
  int n_views = 0;
  int n_bad   = 0;
  int n_rel   = 0;
  int n_cmp   = 0;
  int n_full  = 0;
  int n_miss  = 0;
  int n_peak  = 0;
  int quiet_cycles = 0;

  edf_task_table u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .command_i           (command_i),
    .task_id_i           (task_id_i),
    .now_i               (now_i),
    .relative_deadline_i (relative_deadline_i),
    .completion_time_i   (completion_time_i),
    .due_time_i          (due_time_i),
    .done_o              (done_o),
    .run_valid_o         (run_valid_o),
    .run_task_id_o       (run_task_id_o),
    .active_count_o      (active_count_o),
    .completed_count_o   (completed_count_o),
    .overdue_count_o     (overdue_count_o),
    .status_o            (status_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [DataW-1:0] sat_bump(input logic [DataW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // apply one item to the shadow table and return the result it must give
  function automatic sched_view_t edf_apply(input sched_cmd_t it);
    logic [DataW-1:0] dl;
    int pos;
    sched_view_t r;
    r.status = StatusOk;
    pos = 0;
    if (it.cmd == CmdRelease) begin
      n_rel++;
      dl = it.now + it.rel;
      if (shadow_task.size() >= MaxActive) begin
        r.status = StatusFull;
        n_full++;
      end else begin
        while (pos < shadow_dl.size() && shadow_dl[pos] <= dl) pos++;
        shadow_dl.insert(pos, dl);
        shadow_task.insert(pos, it.id);
      end
    end else begin
      n_cmp++;
      while (pos < shadow_task.size() && shadow_task[pos] != it.id) pos++;
      if (pos >= shadow_task.size()) begin
        r.status = StatusNotFound;
        n_miss++;
      end else begin
        shadow_dl.delete(pos);
        shadow_task.delete(pos);
        if (it.fin > it.due) cnt_late = sat_bump(cnt_late);
        else cnt_on_time = sat_bump(cnt_on_time);
      end
    end
    if (shadow_task.size() > n_peak) n_peak = shadow_task.size();
    r.run_valid = (shadow_task.size() > 0);
    r.run_id    = (shadow_task.size() > 0) ? shadow_task[0] : '0;
    r.active    = CountW'(shadow_task.size());
    r.on_time   = cnt_on_time;
    r.late      = cnt_late;
    return r;
  endfunction

  task automatic queue_cmd(input logic c, input logic [DataW-1:0] id,
                           input logic [DataW-1:0] now, input logic [DataW-1:0] rel,
                           input logic [DataW-1:0] fin, input logic [DataW-1:0] due);
    sched_cmd_t it;
    int k;
    it.cmd = c;
    it.id  = id;
    it.now = now;
    it.rel = rel;
    it.fin = fin;
    it.due = due;
    cmd_backlog.push_back(it);
    if (c == CmdRelease) begin
      if (live_ids.size() < MaxActive) live_ids.push_back(id);
    end else begin
      for (k = 0; k < live_ids.size(); k++) begin
        if (live_ids[k] == id) begin
          live_ids.delete(k);
          break;
        end
      end
    end
  endtask

  function automatic logic [DataW-1:0] pick_id();
    return ($urandom_range(0, 99) < 70) ? DataW'($urandom_range(0, 31)) : DataW'($urandom);
  endfunction

  function automatic logic [DataW-1:0] pick_tick();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return DataW'($urandom_range(0, 63));
      3:       return '1 - DataW'($urandom_range(0, 63));
      default: return DataW'($urandom);
    endcase
  endfunction

  // driver: hold the item until accepted, then advance or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        view_expected.push_back(edf_apply(on_bus));
        n_items++;
      end
      if (!start_i || !busy_o) begin
        if (cmd_backlog.size() > 0 &&
            ((n_items >= 700 && n_items < 1000) || $urandom_range(0, 99) >= 14)) begin
          on_bus = cmd_backlog.pop_front();
          start_i             <= 1'b1;
          command_i           <= on_bus.cmd;
          task_id_i           <= on_bus.id;
          now_i               <= on_bus.now;
          relative_deadline_i <= on_bus.rel;
          completion_time_i   <= on_bus.fin;
          due_time_i          <= on_bus.due;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    sched_view_t e;
    if (rst_ni && done_o) begin
      n_views++;
      if (view_expected.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("ERROR: result with nothing expected, id %h status %0d",
                                  run_task_id_o, status_o);
      end else begin
        e = view_expected.pop_front();
        if (run_valid_o !== e.run_valid || run_task_id_o !== e.run_id ||
            active_count_o !== e.active || completed_count_o !== e.on_time ||
            overdue_count_o !== e.late || status_o !== e.status) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("ERROR: result %0d mismatch", n_views);
            $display("  run_valid exp %0b got %0b, run_task_id exp %h got %h",
                     e.run_valid, run_valid_o, e.run_id, run_task_id_o);
            $display("  active exp %0d got %0d, status exp %0d got %0d",
                     e.active, active_count_o, e.status, status_o);
            $display("  completed exp %0d got %0d, overdue exp %0d got %0d",
                     e.on_time, completed_count_o, e.late, overdue_count_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("ERROR: no progress for %0d cycles", StallLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int i;
    int bias;
    logic [DataW-1:0] due;

    // directed: miss on empty, wrap, ties, duplicates, late and on-time finishes
    queue_cmd(CmdComplete, 32'd5, '0, '0, '0, '0);
    queue_cmd(CmdRelease, '0, '1, 32'd1, '0, '0);
    queue_cmd(CmdRelease, '1, '0, '0, '1, '1);
    queue_cmd(CmdRelease, 32'd7, '1, '1, '0, '0);
    queue_cmd(CmdRelease, 32'd7, 32'd10, 32'd5, '0, '0);
    queue_cmd(CmdComplete, 32'd7, '0, '0, 32'd15, 32'd15);
    queue_cmd(CmdComplete, '0, '0, '0, '1, '0);
    queue_cmd(CmdComplete, '0, '1, '1, '0, '1);
    // fill the table, then overflow it
    for (i = 0; i < 15; i++) begin
      queue_cmd(CmdRelease, 32'd100 + i, 32'd1000 - 32'(i * 3), 32'd50, '0, '0);
    end
    queue_cmd(CmdComplete, '1, '0, '0, '0, '1);
    queue_cmd(CmdComplete, 32'd7, '0, '0, 32'd1, 32'd0);

    // random phases with a swept release bias
    bias = 50;
    for (i = 0; i < 1500; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       bias = 25;
          1:       bias = 50;
          2:       bias = 75;
          default: bias = 95;
        endcase
      end
      due = DataW'($urandom);
      if ($urandom_range(0, 99) < bias) begin
        queue_cmd(CmdRelease, pick_id(), pick_tick(), pick_tick(), $urandom, due);
      end else if (live_ids.size() > 0 && $urandom_range(0, 99) < 85) begin
        queue_cmd(CmdComplete, live_ids[$urandom_range(0, live_ids.size() - 1)],
                  $urandom, $urandom,
                  ($urandom_range(0, 99) < 40) ? DataW'($urandom)
                                               : due + DataW'($urandom_range(0, 6)) - 32'd3,
                  due);
      end else begin
        queue_cmd(CmdComplete, pick_id(), $urandom, $urandom, pick_tick(), due);
      end
    end

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || start_i || view_expected.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (view_expected.size() != 0) begin
      n_bad += view_expected.size();
      $display("ERROR: %0d results never arrived", view_expected.size());
    end

    $display("Ran %0d items (%0d releases, %0d completes), checked %0d results",
             n_items, n_rel, n_cmp, n_views);
    $display("Saw %0d full drops, %0d misses, %0d late, %0d on time, peak %0d active",
             n_full, n_miss, cnt_late, cnt_on_time, n_peak);
    if (n_bad == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
